// ----- sv/cgas_pkg.sv -----
// Shared types, codes and the arctangent table of the conical gradient sampler.
package cgas_pkg;

  localparam int unsigned KindW     = 2;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned StartW    = 22;
  localparam int unsigned StepW     = 23;
  localparam int unsigned CovW      = 8;
  localparam int unsigned TableSize = 256;
  localparam int unsigned RatioW    = 8;
  localparam int unsigned ArcW      = 10;
  localparam int unsigned AngleW    = 13;
  localparam int unsigned DivSteps  = 8;

  localparam logic [RatioW-1:0] RatioMax = 8'd128;

  typedef enum logic [KindW-1:0] {
    KindWrite = 2'd0,
    KindSpan  = 2'd1,
    KindPixel = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  localparam logic [ArcW-1:0] ArcQ12 [129] = '{
    10'd0,   10'd5,   10'd10,  10'd15,  10'd20,  10'd25,  10'd31,  10'd36,
    10'd41,  10'd46,  10'd51,  10'd56,  10'd61,  10'd66,  10'd71,  10'd76,
    10'd81,  10'd86,  10'd91,  10'd96,  10'd101, 10'd106, 10'd111, 10'd116,
    10'd121, 10'd126, 10'd131, 10'd136, 10'd140, 10'd145, 10'd150, 10'd155,
    10'd160, 10'd164, 10'd169, 10'd174, 10'd179, 10'd183, 10'd188, 10'd193,
    10'd197, 10'd202, 10'd207, 10'd211, 10'd216, 10'd220, 10'd225, 10'd229,
    10'd234, 10'd238, 10'd243, 10'd247, 10'd252, 10'd256, 10'd260, 10'd265,
    10'd269, 10'd273, 10'd277, 10'd282, 10'd286, 10'd290, 10'd294, 10'd298,
    10'd302, 10'd306, 10'd310, 10'd314, 10'd318, 10'd322, 10'd326, 10'd330,
    10'd334, 10'd338, 10'd342, 10'd346, 10'd349, 10'd353, 10'd357, 10'd360,
    10'd364, 10'd368, 10'd371, 10'd375, 10'd379, 10'd382, 10'd386, 10'd389,
    10'd393, 10'd396, 10'd399, 10'd403, 10'd406, 10'd410, 10'd413, 10'd416,
    10'd419, 10'd423, 10'd426, 10'd429, 10'd432, 10'd435, 10'd439, 10'd442,
    10'd445, 10'd448, 10'd451, 10'd454, 10'd457, 10'd460, 10'd463, 10'd466,
    10'd469, 10'd471, 10'd474, 10'd477, 10'd480, 10'd483, 10'd486, 10'd488,
    10'd491, 10'd494, 10'd496, 10'd499, 10'd502, 10'd504, 10'd507, 10'd509,
    10'd512
  };

endpackage

// ----- sv/cgas_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module cgas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/conical_gradient_angle_sampler.sv -----
// Top level of the conical gradient sampler: span state, ratio divider, angle fold, table.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction per item:
//   kind 0 writes table_word_i into colour table entry table_index_i,
//   kind 1 loads u, v and their per-pixel steps, kind 2 is one pixel,
//   kind 3 is dropped. Kinds 0, 1, 3 and zero-coverage pixels leave the block idle and ready.
// A pixel with nonzero coverage runs accept, setup, 8 divider steps (one
// quotient bit each through a shared compare-and-subtract), angle fold,
// table read and output load. out_valid_o is set and in_ready_o returns
// together when the output register loads, which waits while it is full,
// so no item is taken until such a pixel is done. The table RAM read is registered.
// Output channel (out_valid_o / out_ready_i) holds color_word_o,
// angle_index_o and coverage_out_o in an output register. The block takes
// new items while a result waits there; a pixel that finishes while the
// register is still full holds until the receiver takes the old result.
// Reset clears u, v, the steps and all control; the colour table is
// undefined until written.
module conical_gradient_angle_sampler #(
  parameter int unsigned CoordBits = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                kind_i,
  input  logic [7:0]                table_index_i,
  input  logic [31:0]               table_word_i,
  input  logic signed [21:0]        u_start_i,
  input  logic signed [21:0]        v_start_i,
  input  logic signed [22:0]        u_step_i,
  input  logic signed [22:0]        v_step_i,
  input  logic [7:0]                coverage_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               color_word_o,
  output logic [7:0]                angle_index_o,
  output logic [7:0]                coverage_out_o
);

  localparam int unsigned DivW = CoordBits + 8;
  localparam int unsigned ExtW = CoordBits + 1;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SPrep  = 3'd1;
  localparam logic [2:0] SDiv   = 3'd2;
  localparam logic [2:0] SAngle = 3'd3;
  localparam logic [2:0] SRead  = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;

  logic [CoordBits-1:0] u_now_q, u_now_d, v_now_q, v_now_d;
  logic signed [22:0]   u_incr_q, u_incr_d, v_incr_q, v_incr_d;

  logic [CoordBits-1:0] au_q, au_d, av_q, av_d;
  logic                 un_q, un_d, vn_q, vn_d;
  logic [7:0]           cov_q, cov_d;
  logic                 swap_q, swap_d, hi_zero_q, hi_zero_d;
  logic [DivW-1:0]      rem_q, rem_d, dvs_q, dvs_d;
  logic [7:0]           quo_q, quo_d;
  logic [7:0]           idx_q, idx_d;

  logic                 out_valid_q, out_valid_d;
  logic [31:0]          color_q, color_d;
  logic [7:0]           oidx_q, oidx_d, ocov_q, ocov_d;

  logic                 in_fire;
  logic                 ram_we, ram_re;
  logic [31:0]          ram_rdata;
  logic signed [CoordBits:0] u_inc_ext, v_inc_ext;
  logic [7:0]           ratio;
  logic [12:0]          aq0, aq1, aq2, aq3, aq_rnd;

  assign in_ready_o = (state_q == SIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ram_we     = in_fire && (kind_i == cgas_pkg::KindWrite);
  assign ram_re     = (state_q == SRead);

  assign u_inc_ext = ExtW'(u_incr_q);
  assign v_inc_ext = ExtW'(v_incr_q);

  assign ratio  = hi_zero_q ? 8'd0 :
                  (quo_q > cgas_pkg::RatioMax) ? cgas_pkg::RatioMax : quo_q;
  assign aq0    = 13'(cgas_pkg::ArcQ12[ratio]);
  assign aq1    = swap_q ? (13'd1024 - aq0) : aq0;
  assign aq2    = un_q ? (13'd2048 - aq1) : aq1;
  assign aq3    = vn_q ? (13'd4096 - aq2) : aq2;
  assign aq_rnd = aq3 + 13'd8;

  cgas_ram #(
    .Width(cgas_pkg::WordW),
    .Depth(cgas_pkg::TableSize)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(table_index_i),
    .wdata_i(table_word_i),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    u_now_d     = u_now_q;
    v_now_d     = v_now_q;
    u_incr_d    = u_incr_q;
    v_incr_d    = v_incr_q;
    au_d        = au_q;
    av_d        = av_q;
    un_d        = un_q;
    vn_d        = vn_q;
    cov_d       = cov_q;
    swap_d      = swap_q;
    hi_zero_d   = hi_zero_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    color_d     = color_q;
    oidx_d      = oidx_q;
    ocov_d      = ocov_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (in_fire) begin
          case (kind_i)
            cgas_pkg::KindSpan: begin
              u_now_d  = CoordBits'(u_start_i);
              v_now_d  = CoordBits'(v_start_i);
              u_incr_d = u_step_i;
              v_incr_d = v_step_i;
            end
            cgas_pkg::KindPixel: begin
              un_d    = u_now_q[CoordBits-1];
              vn_d    = v_now_q[CoordBits-1];
              au_d    = u_now_q[CoordBits-1] ? (~u_now_q + CoordBits'(1)) : u_now_q;
              av_d    = v_now_q[CoordBits-1] ? (~v_now_q + CoordBits'(1)) : v_now_q;
              cov_d   = coverage_i;
              u_now_d = u_now_q + u_inc_ext[CoordBits-1:0];
              v_now_d = v_now_q + v_inc_ext[CoordBits-1:0];
              if (coverage_i != 8'd0) begin
                state_d = SPrep;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SPrep: begin
        swap_d    = (au_q < av_q);
        hi_zero_d = (au_q == '0) && (av_q == '0);
        if (au_q < av_q) begin
          dvs_d = DivW'({av_q, 7'd0});
          rem_d = DivW'({au_q, 7'd0}) + DivW'(av_q >> 1);
        end else begin
          dvs_d = DivW'({au_q, 7'd0});
          rem_d = DivW'({av_q, 7'd0}) + DivW'(au_q >> 1);
        end
        quo_d   = '0;
        cnt_d   = '0;
        state_d = SDiv;
      end
      SDiv: begin
        if (rem_q >= dvs_q) begin
          rem_d = rem_q - dvs_q;
          quo_d = {quo_q[6:0], 1'b1};
        end else begin
          quo_d = {quo_q[6:0], 1'b0};
        end
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(cgas_pkg::DivSteps - 1)) begin
          state_d = SAngle;
        end
      end
      SAngle: begin
        idx_d   = aq_rnd[11:4];
        state_d = SRead;
      end
      SRead: begin
        state_d = SOut;
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          color_d     = ram_rdata;
          oidx_d      = idx_q;
          ocov_d      = cov_q;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      u_now_q     <= '0;
      v_now_q     <= '0;
      u_incr_q    <= '0;
      v_incr_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      u_now_q     <= u_now_d;
      v_now_q     <= v_now_d;
      u_incr_q    <= u_incr_d;
      v_incr_q    <= v_incr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    au_q      <= au_d;
    av_q      <= av_d;
    un_q      <= un_d;
    vn_q      <= vn_d;
    cov_q     <= cov_d;
    swap_q    <= swap_d;
    hi_zero_q <= hi_zero_d;
    rem_q     <= rem_d;
    dvs_q     <= dvs_d;
    quo_q     <= quo_d;
    idx_q     <= idx_d;
    color_q   <= color_d;
    oidx_q    <= oidx_d;
    ocov_q    <= ocov_d;
  end

  assign out_valid_o    = out_valid_q;
  assign color_word_o   = color_q;
  assign angle_index_o  = oidx_q;
  assign coverage_out_o = ocov_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (kind_i == cgas_pkg::KindPixel) && (coverage_i != 8'd0) |=> state_q == SPrep)
    else $error("covered pixel did not start the divider");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SDiv |=> (state_q == SDiv) || (state_q == SAngle))
    else $error("divider left early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) && out_valid_q && !out_ready_i |=> state_q == SOut)
    else $error("result overwrote a pending output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SAngle |=> ##1 (state_q == SOut) && $stable(idx_q))
    else $error("table read index changed before output");

endmodule

// ----- verif/conical_gradient_angle_sampler_tb.sv -----
// Testbench of the conical gradient angle sampler: queued stimulus, mirror predictor, checker.
module conical_gradient_angle_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CoordBits   = 24;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 50;
  localparam int RandomItems = 640;
  localparam int StartSpan   = 1048576;
  localparam int StepSpan    = 2097152;

  localparam int IndexW    = cgas_pkg::IndexW;
  localparam int WordW     = cgas_pkg::WordW;
  localparam int StartW    = cgas_pkg::StartW;
  localparam int StepW     = cgas_pkg::StepW;
  localparam int CovW      = cgas_pkg::CovW;
  localparam int TableSize = cgas_pkg::TableSize;

  localparam logic [9:0] SweepArc [129] = '{
    10'd0,   10'd5,   10'd10,  10'd15,  10'd20,  10'd25,  10'd31,  10'd36,
    10'd41,  10'd46,  10'd51,  10'd56,  10'd61,  10'd66,  10'd71,  10'd76,
    10'd81,  10'd86,  10'd91,  10'd96,  10'd101, 10'd106, 10'd111, 10'd116,
    10'd121, 10'd126, 10'd131, 10'd136, 10'd140, 10'd145, 10'd150, 10'd155,
    10'd160, 10'd164, 10'd169, 10'd174, 10'd179, 10'd183, 10'd188, 10'd193,
    10'd197, 10'd202, 10'd207, 10'd211, 10'd216, 10'd220, 10'd225, 10'd229,
    10'd234, 10'd238, 10'd243, 10'd247, 10'd252, 10'd256, 10'd260, 10'd265,
    10'd269, 10'd273, 10'd277, 10'd282, 10'd286, 10'd290, 10'd294, 10'd298,
    10'd302, 10'd306, 10'd310, 10'd314, 10'd318, 10'd322, 10'd326, 10'd330,
    10'd334, 10'd338, 10'd342, 10'd346, 10'd349, 10'd353, 10'd357, 10'd360,
    10'd364, 10'd368, 10'd371, 10'd375, 10'd379, 10'd382, 10'd386, 10'd389,
    10'd393, 10'd396, 10'd399, 10'd403, 10'd406, 10'd410, 10'd413, 10'd416,
    10'd419, 10'd423, 10'd426, 10'd429, 10'd432, 10'd435, 10'd439, 10'd442,
    10'd445, 10'd448, 10'd451, 10'd454, 10'd457, 10'd460, 10'd463, 10'd466,
    10'd469, 10'd471, 10'd474, 10'd477, 10'd480, 10'd483, 10'd486, 10'd488,
    10'd491, 10'd494, 10'd496, 10'd499, 10'd502, 10'd504, 10'd507, 10'd509,
    10'd512
  };

  typedef struct {
    cgas_pkg::kind_e            kind;
    logic [IndexW-1:0]          index;
    logic [WordW-1:0]           word;
    logic signed [StartW-1:0]   u_start;
    logic signed [StartW-1:0]   v_start;
    logic signed [StepW-1:0]    u_step;
    logic signed [StepW-1:0]    v_step;
    logic [CovW-1:0]            cov;
  } raster_item_t;

  typedef struct {
    logic [WordW-1:0]  word;
    logic [IndexW-1:0] index;
    logic [CovW-1:0]   cov;
  } pixel_result_t;

  logic                     clk_i          = 1'b0;
  logic                     rst_ni         = 1'b0;
  logic                     in_valid_i     = 1'b0;
  logic                     in_ready_o;
  cgas_pkg::kind_e          kind_i         = cgas_pkg::KindWrite;
  logic [IndexW-1:0]        table_index_i  = '0;
  logic [WordW-1:0]         table_word_i   = '0;
  logic signed [StartW-1:0] u_start_i      = '0;
  logic signed [StartW-1:0] v_start_i      = '0;
  logic signed [StepW-1:0]  u_step_i       = '0;
  logic signed [StepW-1:0]  v_step_i       = '0;
  logic [CovW-1:0]          coverage_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i    = 1'b0;
  logic [WordW-1:0]         color_word_o;
  logic [IndexW-1:0]        angle_index_o;
  logic [CovW-1:0]          coverage_out_o;

  raster_item_t  raster_items [$];
  pixel_result_t expected_pixels [$];
  raster_item_t  bus_item;
  pixel_result_t want;

  logic [WordW-1:0]     mirror_table [TableSize];
  logic [CoordBits-1:0] mirror_u = '0;
  logic [CoordBits-1:0] mirror_v = '0;
  logic [StepW-1:0]     mirror_du = '0;
  logic [StepW-1:0]     mirror_dv = '0;

  int errors      = 0;
  int gap_left    = 0;
  int burst_left  = 0;
  int ready_left  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  conical_gradient_angle_sampler #(
    .CoordBits(CoordBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .table_index_i (table_index_i),
    .table_word_i  (table_word_i),
    .u_start_i     (u_start_i),
    .v_start_i     (v_start_i),
    .u_step_i      (u_step_i),
    .v_step_i      (v_step_i),
    .coverage_i    (coverage_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_word_o  (color_word_o),
    .angle_index_o (angle_index_o),
    .coverage_out_o(coverage_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, exp_val, $realtime);
    errors++;
  endtask

  function automatic logic [IndexW-1:0] sweep_index(logic [CoordBits-1:0] u,
                                                     logic [CoordBits-1:0] v);
    logic [CoordBits-1:0] au;
    logic [CoordBits-1:0] av;
    logic [CoordBits-1:0] hi;
    logic [CoordBits-1:0] lo;
    longint unsigned      ratio;
    int                   aq;
    au = u[CoordBits-1] ? (~u + 1'b1) : u;
    av = v[CoordBits-1] ? (~v + 1'b1) : v;
    hi = (au >= av) ? au : av;
    lo = (au >= av) ? av : au;
    if (hi == '0) ratio = 0;
    else ratio = ((64'(lo) << 7) + (64'(hi) >> 1)) / 64'(hi);
    if (ratio > 128) ratio = 128;
    aq = SweepArc[ratio];
    if (au < av) aq = 1024 - aq;
    if (u[CoordBits-1]) aq = 2048 - aq;
    if (v[CoordBits-1]) aq = 4096 - aq;
    return IndexW'((aq + 8) >> 4);
  endfunction

  task automatic trace_item(raster_item_t it);
    pixel_result_t     res;
    logic [IndexW-1:0] idx;
    case (it.kind)
      cgas_pkg::KindWrite: mirror_table[it.index] = it.word;
      cgas_pkg::KindSpan: begin
        mirror_u  = {{(CoordBits-StartW){it.u_start[StartW-1]}}, it.u_start};
        mirror_v  = {{(CoordBits-StartW){it.v_start[StartW-1]}}, it.v_start};
        mirror_du = it.u_step;
        mirror_dv = it.v_step;
      end
      cgas_pkg::KindPixel: begin
        if (it.cov != '0) begin
          idx       = sweep_index(mirror_u, mirror_v);
          res.word  = mirror_table[idx];
          res.index = idx;
          res.cov   = it.cov;
          expected_pixels.push_back(res);
        end
        mirror_u = mirror_u + {{(CoordBits-StepW){mirror_du[StepW-1]}}, mirror_du};
        mirror_v = mirror_v + {{(CoordBits-StepW){mirror_dv[StepW-1]}}, mirror_dv};
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [StartW-1:0] rand_start();
    int val;
    case ($urandom_range(0, 4))
      0, 1: val = int'($urandom_range(0, 2 * StartSpan)) - StartSpan;
      2: val = int'($urandom_range(0, 128)) - 64;
      3: val = $urandom_range(0, 1) ? StartSpan : -StartSpan;
      default: val = 0;
    endcase
    return StartW'(val);
  endfunction

  function automatic logic signed [StepW-1:0] rand_step();
    int val;
    case ($urandom_range(0, 4))
      0, 1: val = int'($urandom_range(0, 2 * StepSpan)) - StepSpan;
      2: val = int'($urandom_range(0, 4096)) - 2048;
      3: val = $urandom_range(0, 1) ? StepSpan : -StepSpan;
      default: val = 0;
    endcase
    return StepW'(val);
  endfunction

  function automatic logic [CovW-1:0] rand_cov();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CovW'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic raster_item_t scatter_item(cgas_pkg::kind_e k);
    raster_item_t it;
    it.kind    = k;
    it.index   = IndexW'($urandom);
    it.word    = $urandom;
    it.u_start = rand_start();
    it.v_start = rand_start();
    it.u_step  = rand_step();
    it.v_step  = rand_step();
    it.cov     = CovW'($urandom);
    return it;
  endfunction

  task automatic push_write(logic [IndexW-1:0] idx, logic [WordW-1:0] word);
    raster_item_t it;
    it       = scatter_item(cgas_pkg::KindWrite);
    it.index = idx;
    it.word  = word;
    raster_items.push_back(it);
  endtask

  task automatic push_span(int us, int vs, int dus, int dvs);
    raster_item_t it;
    it         = scatter_item(cgas_pkg::KindSpan);
    it.u_start = StartW'(us);
    it.v_start = StartW'(vs);
    it.u_step  = StepW'(dus);
    it.v_step  = StepW'(dvs);
    raster_items.push_back(it);
  endtask

  task automatic push_pixel(logic [CovW-1:0] cov);
    raster_item_t it;
    it     = scatter_item(cgas_pkg::KindPixel);
    it.cov = cov;
    raster_items.push_back(it);
  endtask

  task automatic push_span_random();
    raster_item_t it;
    it = scatter_item(cgas_pkg::KindSpan);
    raster_items.push_back(it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        trace_item(bus_item);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (raster_items.size() > 0) begin
          bus_item = raster_items.pop_front();
          kind_i        <= bus_item.kind;
          table_index_i <= bus_item.index;
          table_word_i  <= bus_item.word;
          u_start_i     <= bus_item.u_start;
          v_start_i     <= bus_item.v_start;
          u_step_i      <= bus_item.u_step;
          v_step_i      <= bus_item.v_step;
          coverage_i    <= bus_item.cov;
          in_valid_i    <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected result", color_word_o, 32'd0);
      end else begin
        want = expected_pixels.pop_front();
        if (color_word_o !== want.word)
          report_mismatch("color_word", color_word_o, want.word);
        if (angle_index_o !== want.index)
          report_mismatch("angle_index", 32'(angle_index_o), 32'(want.index));
        if (coverage_out_o !== want.cov)
          report_mismatch("coverage_out", 32'(coverage_out_o), 32'(want.cov));
      end
    end
    if (ready_left > 0) begin
      ready_left--;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      ready_left = $urandom_range(1, 25);
      stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int           counted;
    int           run;
    int           sel;
    raster_item_t it;

    // preload the whole table so that no pixel reads an unwritten entry
    for (int i = 0; i < TableSize; i++) begin
      push_write(IndexW'(i),
                 (i == 0) ? 32'h0 : (i == TableSize - 1) ? 32'hFFFF_FFFF : $urandom);
    end

    // walk u through zero, the most negative value and the wrap
    push_span(0, 0, -StepSpan, 0);
    push_pixel(8'd255);
    push_pixel(8'd0);
    push_pixel(8'd1);
    push_pixel(8'd128);
    push_pixel(8'd255);
    push_pixel(8'd255);
    raster_items.push_back(scatter_item(cgas_pkg::KindNone));
    push_span(StartSpan, -StartSpan, StepSpan, StepSpan);
    push_pixel(8'd255);
    push_pixel(8'd77);
    push_span(-StartSpan, StartSpan, 0, 0);
    push_pixel(8'd255);
    push_span(0, StartSpan, 0, 0);
    push_pixel(8'd255);
    push_span(-1, 0, 0, 0);
    push_pixel(8'd255);
    push_write(8'd0, 32'hFFFF_FFFF);
    push_write(8'd255, 32'h0);
    // an angle of a full turn lands on entry zero
    push_span(StartSpan, -1, 0, 0);
    push_pixel(8'd255);
    push_span(1, -StartSpan, -StepSpan, StepSpan);
    push_pixel(8'd200);
    push_pixel(8'd255);

    counted = 0;
    while (counted < RandomItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        push_write(IndexW'($urandom), $urandom);
        counted++;
      end else if (sel < 13) begin
        raster_items.push_back(scatter_item(cgas_pkg::KindNone));
      end else if (sel < 20) begin
        run = $urandom_range(1, 4);
        for (int p = 0; p < run; p++) push_pixel(rand_cov());
        counted += run;
      end else begin
        push_span_random();
        run = $urandom_range(1, 24);
        for (int p = 0; p < run; p++) begin
          if ($urandom_range(0, 19) == 0) begin
            it = scatter_item(cgas_pkg::KindNone);
            raster_items.push_back(it);
          end
          push_pixel(rand_cov());
        end
        counted += run + 1;
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (raster_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_pixels.size() != 0)
      report_mismatch("missing results", 32'(expected_pixels.size()), 32'd0);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cgas_pkg.sv
sv/cgas_ram.sv
sv/conical_gradient_angle_sampler.sv
verif/conical_gradient_angle_sampler_tb.sv
